// ----- hw/rtl/b64d_pkg.sv -----
// b64d_pkg: shared types, constants and the character classifier of the
// base64 stream decoder. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  // default depth of the group queue between front and back
  localparam int unsigned QDepthDefault = 4;

  localparam int unsigned SextW  = 6;
  localparam int unsigned AccW   = 18;
  localparam int unsigned GroupW = 24;

  // one character after classification
  typedef struct packed {
    logic [SextW-1:0] sext;
    logic             pad;
    logic             illegal;
  } b64d_class_t;

  // work for the back end: up to three bytes, then optionally the status word
  typedef struct packed {
    logic [GroupW-1:0] group;
    logic [1:0]        nbytes;
    logic              status;
    logic              bad;
  } b64d_rec_t;

  function automatic b64d_class_t b64d_classify(input logic [7:0] c);
    b64d_class_t r;
    r.sext    = '0;
    r.pad     = 1'b0;
    r.illegal = 1'b0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.sext = SextW'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.sext = SextW'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.sext = SextW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.sext = SextW'(62);
    end else if (c == 8'h2F) begin
      r.sext = SextW'(63);
    end else if (c == 8'h3D) begin
      r.pad = 1'b1;
    end else begin
      r.illegal = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/b64d_if.sv -----
// b64d_in_if, b64d_out_if: valid/ready channels of the base64 decoder.
// Depend on nothing.
`timescale 1ns / 1ps

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_final;

  modport source (output valid, char_in, is_final, input ready);
  modport sink   (input valid, char_in, is_final, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_status;
  logic       bad_input;
  logic       run_end;

  modport source (output valid, data_byte, is_status, bad_input, run_end, input ready);
  modport sink   (input valid, data_byte, is_status, bad_input, run_end, output ready);
endinterface

// ----- hw/rtl/b64d_front.sv -----
// b64d_front: takes characters, tracks group position and error state, and
// pushes a record per valid group or stream end. Uses b64d_pkg, b64d_in_if.
`timescale 1ns / 1ps

module b64d_front import b64d_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  b64d_in_if.sink      in_ch_i,
  input  logic         q_full_i,
  output logic         push_o,
  output b64d_rec_t    rec_o
);

  logic [1:0]      pos_q, pos_d, pos_inc;
  logic [AccW-1:0] acc_q, acc_d;
  logic            third_q, third_d;
  logic            padded_q, padded_d;
  logic            err_q, err_d;

  b64d_class_t cls;
  logic        accept;
  logic        last_pos;
  logic        err_now;
  logic        emit;
  logic [1:0]  nbytes;

  assign cls      = b64d_classify(in_ch_i.char_in);
  assign in_ch_i.ready = !q_full_i;
  assign accept   = in_ch_i.valid && !q_full_i;
  assign last_pos = (pos_q == 2'd3);
  assign pos_inc  = pos_q + 2'd1;

  // padding only legal in the last two positions, and "=x" is broken
  assign err_now = err_q | cls.illegal | padded_q | (!pos_q[1] & cls.pad)
                 | (last_pos & third_q & !cls.pad);
  assign emit    = last_pos & !err_now;
  assign nbytes  = cls.pad ? (third_q ? 2'd1 : 2'd2) : 2'd3;

  always_comb begin
    rec_o.group  = {acc_q, cls.sext};
    rec_o.nbytes = emit ? nbytes : 2'd0;
    rec_o.status = in_ch_i.is_final;
    rec_o.bad    = err_now | (pos_inc != 2'd0);
  end

  assign push_o = accept && (emit || in_ch_i.is_final);

  always_comb begin
    pos_d    = pos_q;
    acc_d    = acc_q;
    third_d  = third_q;
    padded_d = padded_q;
    err_d    = err_q;
    if (accept) begin
      if (in_ch_i.is_final) begin
        pos_d    = '0;
        acc_d    = '0;
        third_d  = 1'b0;
        padded_d = 1'b0;
        err_d    = 1'b0;
      end else begin
        pos_d = pos_inc;
        err_d = err_now;
        if (last_pos) begin
          acc_d    = '0;
          third_d  = 1'b0;
          padded_d = padded_q | cls.pad;
        end else begin
          acc_d = {acc_q[AccW-SextW-1:0], cls.sext};
          if (pos_q == 2'd2) begin
            third_d = cls.pad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      acc_q    <= '0;
      third_q  <= 1'b0;
      padded_q <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      third_q  <= third_d;
      padded_q <= padded_d;
      err_q    <= err_d;
    end
  end

endmodule

// ----- hw/rtl/b64d_queue.sv -----
// b64d_queue: small register queue of group records between front and back.
// Uses b64d_pkg.
`timescale 1ns / 1ps

module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = QDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b64d_rec_t rec_i,
  input  logic      pop_i,
  output b64d_rec_t head_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  b64d_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/b64d_back.sv -----
// b64d_back: walks the head record into the output register one word per
// cycle while out_ch_o is ready. Uses b64d_pkg, b64d_out_if.
`timescale 1ns / 1ps

module b64d_back import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  b64d_rec_t  head_i,
  input  logic       empty_i,
  output logic       pop_o,
  b64d_out_if.source out_ch_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       stat_q, stat_d;
  logic       bad_q, bad_d;
  logic       end_q, end_d;

  logic       load;
  logic [2:0] total;
  logic       last;
  logic       is_byte;
  logic [7:0] sel_byte;

  assign load    = !vld_q || out_ch_o.ready;
  assign total   = {1'b0, head_i.nbytes} + {2'b00, head_i.status};
  assign last    = ({1'b0, idx_q} == total - 3'd1);
  assign is_byte = (idx_q < head_i.nbytes);
  assign pop_o   = load && !empty_i && last;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.group[23:16];
      2'd1:    sel_byte = head_i.group[15:8];
      2'd2:    sel_byte = head_i.group[7:0];
      default: sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    stat_d = stat_q;
    bad_d  = bad_q;
    end_d  = end_q;
    if (load) begin
      vld_d = !empty_i;
      if (!empty_i) begin
        byte_d = is_byte ? sel_byte : 8'h00;
        stat_d = !is_byte;
        bad_d  = !is_byte && head_i.bad;
        end_d  = last;
        idx_d  = last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    stat_q <= stat_d;
    bad_q  <= bad_d;
    end_q  <= end_d;
  end

  assign out_ch_o.valid     = vld_q;
  assign out_ch_o.data_byte = byte_q;
  assign out_ch_o.is_status = stat_q;
  assign out_ch_o.bad_input = bad_q;
  assign out_ch_o.run_end   = end_q;

endmodule

// ----- hw/rtl/base64_stream_decoder_unit.sv -----
// base64_stream_decoder_unit: strict base64 decoder, top level.
// Uses b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
//
// Usage:
//   in_ch_i takes one base64 character per word, is_final marking the last
//   one of a stream. out_ch_o gives decoded bytes, and after the final
//   character one status word (is_status = 1, bad_input = stream invalid).
//   run_end flags the last word caused by an input character.
// Path and throughput:
//   the fourth character of a group passes the record queue and the
//   output register before its first byte shows; the remaining bytes and
//   the status word follow one per cycle while out_ch_o is ready. So one
//   character per cycle is sustained without back-pressure: four characters
//   yield at most three bytes, or four words with the status word.
// Reset:
//   clears group position, error and padding state and empties the queue.
//   The state also returns to reset after each final character.
// Stalls:
//   when out_ch_o is held off, words wait in the output register and the
//   queue (QDepth records); in_ch_i.ready drops only once the queue is full.
`timescale 1ns / 1ps

module base64_stream_decoder_unit import b64d_pkg::*; #(
  parameter int unsigned QDepth = QDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64d_in_if.sink    in_ch_i,
  b64d_out_if.source out_ch_o
);

  b64d_rec_t rec;
  b64d_rec_t head;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .rec_o    (rec)
  );

  b64d_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (rec),
    .pop_i   (q_pop),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  b64d_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .empty_i  (q_empty),
    .pop_o    (q_pop),
    .out_ch_o (out_ch_o)
  );

`ifndef NO_ASSERTIONS
  // the status word always closes the run of its character
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && out_ch_o.is_status |-> out_ch_o.run_end)
    else $error("status word without run_end");

  // data words never carry the error flag
  a_bad_only_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid && !out_ch_o.is_status |-> !out_ch_o.bad_input)
    else $error("bad_input on a data word");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a queued record must show up at the output next cycle when it drains
  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> out_ch_o.valid && out_ch_o.run_end)
    else $error("record retired without its last word");
`endif

endmodule

// ----- sim/b64d_decode_checker.sv -----
// b64d_decode_checker: watches both channels of the base64 decoder, predicts
// the decoded bytes and status words, and compares them in order.
// Plain signal ports; no package dependency.
`timescale 1ns / 1ps

module b64d_decode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  char_i,
  input  logic        final_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  data_i,
  input  logic        status_i,
  input  logic        bad_i,
  input  logic        run_end_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam logic [7:0] ChUpA  = "A";
  localparam logic [7:0] ChUpZ  = "Z";
  localparam logic [7:0] ChLoA  = "a";
  localparam logic [7:0] ChLoZ  = "z";
  localparam logic [7:0] ChDig0 = "0";
  localparam logic [7:0] ChDig9 = "9";
  localparam logic [7:0] ChPlus = "+";
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChPad  = "=";

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       bad;
    logic       last;
  } dec_word_t;

  dec_word_t   exp_words[$];
  logic [1:0]  grp_pos;
  logic [17:0] sext_acc;
  logic        third_pad;
  logic        pad_seen;
  logic        err;
  int unsigned fails;

  function automatic dec_word_t make_word(input logic [7:0] d, input logic st,
                                          input logic bd);
    dec_word_t w;
    w.data   = d;
    w.status = st;
    w.bad    = bd;
    w.last   = 1'b0;
    return w;
  endfunction

  // updates the decoder state for one character and queues what it yields
  task automatic predict_char(input logic [7:0] c, input logic fin);
    logic [5:0]  sx;
    logic        is_pad;
    logic [23:0] grp;
    int          nb;
    dec_word_t   yield[$];
    sx     = '0;
    is_pad = 1'b0;
    if (c >= ChUpA && c <= ChUpZ) begin
      sx = 6'(c - ChUpA);
    end else if (c >= ChLoA && c <= ChLoZ) begin
      sx = 6'(c - ChLoA + 8'd26);
    end else if (c >= ChDig0 && c <= ChDig9) begin
      sx = 6'(c - ChDig0 + 8'd52);
    end else if (c == ChPlus) begin
      sx = 6'd62;
    end else if (c == ChSlash) begin
      sx = 6'd63;
    end else if (c == ChPad) begin
      is_pad = 1'b1;
    end else begin
      err = 1'b1;
    end
    if (pad_seen) err = 1'b1;

    if (grp_pos != 2'd3) begin
      if (grp_pos != 2'd2 && is_pad) err = 1'b1;
      if (grp_pos == 2'd2) third_pad = is_pad;
      sext_acc = {sext_acc[11:0], sx};
    end else begin
      if (third_pad && !is_pad) err = 1'b1;
      grp = {sext_acc, sx};
      nb  = is_pad ? (third_pad ? 1 : 2) : 3;
      if (!err) begin
        yield.push_back(make_word(grp[23:16], 1'b0, 1'b0));
        if (nb > 1) yield.push_back(make_word(grp[15:8], 1'b0, 1'b0));
        if (nb > 2) yield.push_back(make_word(grp[7:0], 1'b0, 1'b0));
      end
      if (is_pad) pad_seen = 1'b1;
      third_pad = 1'b0;
      sext_acc  = '0;
    end
    grp_pos = grp_pos + 2'd1;

    if (fin) begin
      if (grp_pos != 2'd0) err = 1'b1;
      yield.push_back(make_word(8'h00, 1'b1, err));
      grp_pos   = '0;
      sext_acc  = '0;
      third_pad = 1'b0;
      pad_seen  = 1'b0;
      err       = 1'b0;
    end

    if (yield.size() > 0) yield[yield.size()-1].last = 1'b1;
    foreach (yield[i]) exp_words.push_back(yield[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dec_word_t got;
    dec_word_t want;
    if (!rst_ni) begin
      exp_words.delete();
      grp_pos   = '0;
      sext_acc  = '0;
      third_pad = 1'b0;
      pad_seen  = 1'b0;
      err       = 1'b0;
      fails     = 0;
    end else begin
      // a word leaving now cannot come from a character taken at this edge
      if (out_valid_i && out_ready_i) begin
        got.data   = data_i;
        got.status = status_i;
        got.bad    = bad_i;
        got.last   = run_end_i;
        if (exp_words.size() == 0) begin
          fails++;
          $display("%0t: unexpected word data=%02h status=%b bad=%b run_end=%b",
                   $time, got.data, got.status, got.bad, got.last);
        end else begin
          want = exp_words.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: mismatch expected data=%02h status=%b bad=%b run_end=%b",
                     $time, want.data, want.status, want.bad, want.last);
            $display("%0t:          actual   data=%02h status=%b bad=%b run_end=%b",
                     $time, got.data, got.status, got.bad, got.last);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_char(char_i, final_i);
    end
    fail_cnt_o <= fails;
    pending_o  <= exp_words.size();
  end

endmodule

// ----- sim/tb_base64_stream_decoder_unit.sv -----
// tb_base64_stream_decoder_unit: drives base64 streams into the decoder and
// gives the verdict. Uses b64d_if, base64_stream_decoder_unit and
// b64d_decode_checker.
`timescale 1ns / 1ps

module tb_base64_stream_decoder_unit;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 370;
  localparam int unsigned DrainWait  = 16;
  localparam logic [7:0]  ChPad      = "=";

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned src_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned items_sent;
  int unsigned cycle_cnt;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  b64d_decode_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .char_i      (in_ch.char_in),
    .final_i     (in_ch.is_final),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .data_i      (out_ch.data_byte),
    .status_i    (out_ch.is_status),
    .bad_i       (out_ch.bad_input),
    .run_end_i   (out_ch.run_end),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A") + 8'(v);
    if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
    if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
    if (v == 6'd62) return 8'("+");
    return 8'("/");
  endfunction

  // one input word; valid stays high across back-to-back words
  task automatic send_word(input logic [7:0] c, input logic fin);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= c;
    in_ch.is_final <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_word(s[i], fin && (i == s.len() - 1));
  endtask

  // mostly well-formed streams, some with a stray byte, bad length or pad
  task automatic send_random_stream();
    logic [7:0] text[$];
    int         n_grp;
    int         n_pad;
    int         flaw;
    n_grp = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (int i = 0; i < 4 * n_grp; i++) text.push_back(sextet_char(6'($urandom_range(63))));
    n_pad = $urandom_range(2);
    for (int i = 0; i < n_pad; i++) text[text.size() - 1 - i] = ChPad;
    flaw = $urandom_range(9);
    case (flaw)
      7: begin
        text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end
      8: begin
        if ($urandom_range(1) == 0) begin
          void'(text.pop_back());
        end else begin
          repeat ($urandom_range(1, 4)) text.push_back(sextet_char(6'($urandom_range(63))));
        end
      end
      9: begin
        text[$urandom_range(text.size() - 1)] = ChPad;
      end
      default: ;
    endcase
    for (int i = 0; i < text.size(); i++) send_word(text[i], i == text.size() - 1);
  endtask

  // the pending count is registered, so it lags behind the last accepted word
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("base64_stream_decoder_unit verification failed");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.char_in  <= '0;
    in_ch.is_final <= 1'b0;
    src_idle_pct   = 30;
    rcv_idle_pct   = 77;
    items_sent     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero and all-ones groups
    send_text("AAAA////", 1'b1);
    // one-byte pad, then data after the padded group
    send_text("TQ==TWFu", 1'b1);
    send_text("TWE=", 1'b1);
    // pad in second position, length not a multiple of four
    send_text("A=", 1'b1);
    // illegal byte, third pad without fourth
    send_word(8'hFF, 1'b0);
    send_text("W=u", 1'b1);

    while (items_sent < ItemTarget / 3) send_random_stream();

    in_ch.valid <= 1'b0;
    wait_drained();
    src_idle_pct = 77;
    rcv_idle_pct = 30;
    while (items_sent < 2 * ItemTarget / 3) send_random_stream();

    in_ch.valid <= 1'b0;
    wait_drained();
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    while (items_sent < ItemTarget) send_random_stream();

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("base64_stream_decoder_unit verification clean");
    end else begin
      $display("base64_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
